@@ rtl/assert_macros.svh @@
// assertion helpers for the tokenizer, clocked on clk_i, off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/cct_pkg.sv @@
package cct_pkg;

  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned ModeWidth    = 3;
  localparam int unsigned KindWidth    = 2;
  localparam int unsigned ApbAddrWidth = 4;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [ByteWidth-1:0] QuoteByte = 8'd34;

  localparam logic [ByteWidth-1:0] SepAReset = 8'd9;
  localparam logic [ByteWidth-1:0] SepBReset = 8'd44;
  localparam logic [ByteWidth-1:0] LfAReset  = 8'd13;
  localparam logic [ByteWidth-1:0] LfBReset  = 8'd10;

  // register indexes
  localparam logic [1:0] RegSepA = 2'd0;
  localparam logic [1:0] RegSepB = 2'd1;
  localparam logic [1:0] RegLfA  = 2'd2;
  localparam logic [1:0] RegLfB  = 2'd3;

  // parser modes
  localparam logic [ModeWidth-1:0] ModeRowStart  = 3'd0;
  localparam logic [ModeWidth-1:0] ModeCellStart = 3'd1;
  localparam logic [ModeWidth-1:0] ModeUnquoted  = 3'd2;
  localparam logic [ModeWidth-1:0] ModeQuoted    = 3'd3;
  localparam logic [ModeWidth-1:0] ModeQuoteSeen = 3'd4;
  localparam logic [ModeWidth-1:0] ModeSkip      = 3'd5;

  // result kinds
  localparam logic [KindWidth-1:0] KindData    = 2'd0;
  localparam logic [KindWidth-1:0] KindCellEnd = 2'd1;
  localparam logic [KindWidth-1:0] KindRowEnd  = 2'd2;
  localparam logic [KindWidth-1:0] KindError   = 2'd3;

  // error codes
  localparam logic ErrUnterminated = 1'b0;
  localparam logic ErrStrayByte    = 1'b1;

  typedef struct packed {
    logic [ByteWidth-1:0] sep_a;
    logic [ByteWidth-1:0] sep_b;
    logic [ByteWidth-1:0] lf_a;
    logic [ByteWidth-1:0] lf_b;
  } cct_cfg_t;

  typedef struct packed {
    logic [ModeWidth-1:0] mode;
    logic                 cell_open;
    logic                 after_cr;
  } cct_state_t;

  typedef struct packed {
    logic                 valid;
    logic [KindWidth-1:0] kind;
    logic [ByteWidth-1:0] data;
    logic                 closes;
    logic                 err;
  } cct_res_t;

endpackage

@@ rtl/cct_cfg_regs.sv @@
module cct_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cct_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [cct_pkg::ApbDataWidth-1:0] pwdata,
  output logic [cct_pkg::ApbDataWidth-1:0] prdata,
  output cct_pkg::cct_cfg_t                cfg_o
);
  import cct_pkg::*;

  cct_cfg_t             cfg_q;
  logic                 wr_en;
  logic [1:0]           reg_idx;
  logic [ByteWidth-1:0] rd_byte;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep_a <= SepAReset;
      cfg_q.sep_b <= SepBReset;
      cfg_q.lf_a  <= LfAReset;
      cfg_q.lf_b  <= LfBReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSepA: cfg_q.sep_a <= pwdata[ByteWidth-1:0];
        RegSepB: cfg_q.sep_b <= pwdata[ByteWidth-1:0];
        RegLfA:  cfg_q.lf_a  <= pwdata[ByteWidth-1:0];
        RegLfB:  cfg_q.lf_b  <= pwdata[ByteWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSepA: rd_byte = cfg_q.sep_a;
      RegSepB: rd_byte = cfg_q.sep_b;
      RegLfA:  rd_byte = cfg_q.lf_a;
      RegLfB:  rd_byte = cfg_q.lf_b;
      default: rd_byte = '0;
    endcase
  end

  assign prdata = {{(ApbDataWidth-ByteWidth){1'b0}}, rd_byte};
  assign cfg_o  = cfg_q;

endmodule

@@ rtl/cct_step.sv @@
module cct_step (
  input  cct_pkg::cct_cfg_t                cfg_i,
  input  cct_pkg::cct_state_t              state_i,
  input  logic [cct_pkg::ByteWidth-1:0]    byte_i,
  input  logic                             eos_i,
  output cct_pkg::cct_state_t              state_o,
  output cct_pkg::cct_res_t                res_o
);
  import cct_pkg::*;

  logic is_sep;
  logic is_lf;
  logic is_quote;
  logic lf_is_a;

  assign is_sep   = (byte_i == cfg_i.sep_a) || (byte_i == cfg_i.sep_b);
  assign is_lf    = (byte_i == cfg_i.lf_a) || (byte_i == cfg_i.lf_b);
  assign is_quote = (byte_i == QuoteByte);
  assign lf_is_a  = (byte_i == cfg_i.lf_a);

  always_comb begin
    state_o           = state_i;
    state_o.after_cr  = 1'b0;
    res_o             = '0;

    if (eos_i) begin
      state_o.mode      = ModeRowStart;
      state_o.cell_open = 1'b0;
      unique case (state_i.mode) inside
        ModeCellStart: begin
          res_o.valid = 1'b1;
          res_o.kind  = KindRowEnd;
        end
        ModeUnquoted, ModeQuoteSeen: begin
          res_o.valid  = 1'b1;
          res_o.kind   = KindRowEnd;
          res_o.closes = 1'b1;
        end
        ModeQuoted: begin
          res_o.valid = 1'b1;
          res_o.kind  = KindError;
          res_o.err   = ErrUnterminated;
        end
        default: ;
      endcase
    end else begin
      unique case (state_i.mode) inside
        ModeUnquoted: begin
          res_o.valid = 1'b1;
          if (is_sep) begin
            state_o.mode      = ModeCellStart;
            state_o.cell_open = 1'b0;
            res_o.kind        = KindCellEnd;
          end else if (is_lf) begin
            state_o.mode      = ModeRowStart;
            state_o.cell_open = 1'b0;
            state_o.after_cr  = lf_is_a;
            res_o.kind        = KindRowEnd;
            res_o.closes      = 1'b1;
          end else begin
            res_o.kind = KindData;
            res_o.data = byte_i;
          end
        end
        ModeQuoted: begin
          if (is_quote) begin
            state_o.mode = ModeQuoteSeen;
          end else begin
            res_o.valid = 1'b1;
            res_o.kind  = KindData;
            res_o.data  = byte_i;
          end
        end
        ModeQuoteSeen: begin
          res_o.valid = 1'b1;
          if (is_quote) begin
            // doubled quote
            state_o.mode = ModeQuoted;
            res_o.kind   = KindData;
            res_o.data   = byte_i;
          end else if (is_sep) begin
            state_o.mode      = ModeCellStart;
            state_o.cell_open = 1'b0;
            res_o.kind        = KindCellEnd;
          end else if (is_lf) begin
            state_o.mode      = ModeRowStart;
            state_o.cell_open = 1'b0;
            state_o.after_cr  = lf_is_a;
            res_o.kind        = KindRowEnd;
            res_o.closes      = 1'b1;
          end else begin
            state_o.mode      = ModeSkip;
            state_o.cell_open = 1'b0;
            res_o.kind        = KindError;
            res_o.err         = ErrStrayByte;
          end
        end
        ModeSkip: begin
          if (is_lf) begin
            state_o.mode     = ModeRowStart;
            state_o.after_cr = lf_is_a;
          end
        end
        ModeRowStart, ModeCellStart: begin
          if ((state_i.mode == ModeRowStart) && state_i.after_cr
              && (byte_i == cfg_i.lf_b)) begin
            // lf swallowed after cr
          end else if (is_lf) begin
            state_o.mode      = ModeRowStart;
            state_o.cell_open = 1'b0;
            state_o.after_cr  = lf_is_a;
            res_o.valid       = 1'b1;
            res_o.kind        = KindRowEnd;
          end else if (is_quote) begin
            state_o.mode      = ModeQuoted;
            state_o.cell_open = 1'b1;
          end else if (is_sep) begin
            state_o.mode      = ModeCellStart;
            state_o.cell_open = 1'b0;
            res_o.valid       = 1'b1;
            res_o.kind        = KindCellEnd;
          end else begin
            state_o.mode      = ModeUnquoted;
            state_o.cell_open = 1'b1;
            res_o.valid       = 1'b1;
            res_o.kind        = KindData;
            res_o.data        = byte_i;
          end
        end
        default: begin
          state_o.mode      = ModeRowStart;
          state_o.cell_open = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/csv_cell_tokenizer_core.sv @@
// an accepted byte is held in the byte register, then its result in the result register
// throughput: one byte per cycle, sustained while the master side takes results
// the byte register and the result register form a two-stage pipeline; the parse
// state update is a single mode decode between them
// reset: async active low, parse state to row start, registers to tab/comma/cr/lf
`include "assert_macros.svh"

module csv_cell_tokenizer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cct_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [cct_pkg::ApbDataWidth-1:0] pwdata,
  output logic [cct_pkg::ApbDataWidth-1:0] prdata,
  output logic                             pready,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cct_pkg::ByteWidth-1:0]    s_axis_tdata,  // [7:0] text_byte
  input  logic                             s_axis_tlast,  // end_of_stream
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [cct_pkg::OutDataWidth-1:0] m_axis_tdata,  // [7:0] data_byte, [8] closes_cell,
                                                          // [9] error_code, [15:10] zero
  output logic [cct_pkg::KindWidth-1:0]    m_axis_tuser   // [1:0] kind
);
  import cct_pkg::*;

  cct_cfg_t   cfg;

  // input stage
  logic                 in_valid_q;
  logic [ByteWidth-1:0] in_byte_q;
  logic                 in_eos_q;

  // parse state
  cct_state_t state_q;
  cct_state_t state_d;
  cct_res_t   res_d;

  // result stage
  logic                 out_valid_q;
  logic [KindWidth-1:0] out_kind_q;
  logic [ByteWidth-1:0] out_data_q;
  logic                 out_closes_q;
  logic                 out_err_q;

  logic advance;
  logic in_take;

  cct_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  // result register is free when empty or its transaction completes now
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  cct_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .eos_i   (in_eos_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // parse state moves only when the held byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= ModeRowStart;
      state_q.cell_open <= 1'b0;
      state_q.after_cr  <= 1'b0;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_d.valid) begin
      out_kind_q   <= res_d.kind;
      out_data_q   <= res_d.data;
      out_closes_q <= res_d.closes;
      out_err_q    <= res_d.err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {{(OutDataWidth-ByteWidth-2){1'b0}}, out_err_q, out_closes_q,
                          out_data_q};

  // an open cell only exists inside a cell body
  `CCT_ASSERT_IMP(a_cell_open_mode, state_q.cell_open,
    (state_q.mode == ModeUnquoted) || (state_q.mode == ModeQuoted) ||
    (state_q.mode == ModeQuoteSeen))
  // cr memory is only kept at row start
  `CCT_ASSERT_IMP(a_after_cr_mode, state_q.after_cr, state_q.mode == ModeRowStart)
  // data byte is zero on every non-data result
  `CCT_ASSERT_IMP(a_data_zero, m_axis_tvalid && (m_axis_tuser != KindData),
    m_axis_tdata[ByteWidth-1:0] == '0)
  // input side only stalls behind a waiting result
  `CCT_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule
